FILE: rtl/core/bavq_pkg.sv
// Package for the block average xterm-256 quantizer.
// Image geometry, derived widths, queue item types and color constants.
// No dependencies.
`timescale 1ns / 1ps

package bavq_pkg;

  localparam int unsigned IMAGE_WIDTH    = 256;
  localparam int unsigned IMAGE_HEIGHT   = 256;
  localparam int unsigned NUM_BLOCK_COLS = (IMAGE_WIDTH + 3) / 4;

  localparam int unsigned COL_W = ($clog2(IMAGE_WIDTH) < 3) ? 3 : $clog2(IMAGE_WIDTH);
  localparam int unsigned ROW_W = ($clog2(IMAGE_HEIGHT) < 3) ? 3 : $clog2(IMAGE_HEIGHT);
  localparam int unsigned BC_W  = (NUM_BLOCK_COLS > 1) ? $clog2(NUM_BLOCK_COLS) : 1;

  localparam int unsigned CH_W  = 12;
  localparam int unsigned SUM_W = 3 * CH_W;

  // power of two: pointers wrap naturally
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMAGE_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMAGE_HEIGHT - 1);

  localparam logic [7:0]  GRAY_SPREAD = 8'd10;
  localparam logic [7:0]  GRAY_LO     = 8'd8;
  localparam logic [7:0]  GRAY_HI     = 8'd248;
  localparam logic [7:0]  IDX_BLACK   = 8'd16;
  localparam logic [7:0]  IDX_WHITE   = 8'd231;
  localparam logic [8:0]  IDX_RAMP    = 9'd232;
  localparam logic [8:0]  IDX_MAX     = 9'd255;
  localparam logic [7:0]  CUBE_STEP   = 8'd51;
  localparam logic [7:0]  CUBE_R_MUL  = 8'd36;
  localparam logic [7:0]  CUBE_G_MUL  = 8'd6;
  localparam logic [19:0] RECIP3      = 20'd683;  // x/3 = (x*683)>>11, x <= 765
  localparam logic [15:0] RECIP10     = 16'd205;  // x/10 = (x*205)>>11, x <= 240

  typedef struct packed {
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [BC_W-1:0] bcol;
    logic [5:0]      brow;
    logic            first;
    logic            last;
  } pix_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // mean / 51, 0..5
  function automatic logic [2:0] cube_digit(input logic [7:0] x);
    logic [2:0] d;
    d = 3'd0;
    for (int k = 1; k <= 5; k++) begin
      if (x >= 8'(k * CUBE_STEP)) begin
        d = d + 3'd1;
      end
    end
    return d;
  endfunction

endpackage

FILE: rtl/core/bavq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bavq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/bavq_front.sv
// Front end: accepts pixels, tracks raster position, tags block column/row
// and first/last pixel of a block. Depends on bavq_pkg.
`timescale 1ns / 1ps

module bavq_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [23:0]            s_axis_tdata,   // red, green, blue
  input  logic                   s_axis_tuser,   // frame_start
  input  bavq_pkg::fifo_stat_t   fifo_stat_i,
  output logic                   push_o,
  output bavq_pkg::pix_item_t    item_o
);
  import bavq_pkg::*;

  logic [COL_W-1:0] col_q, col_d, cur_col, col_shift;
  logic [ROW_W-1:0] row_q, row_d, cur_row, row_shift;

  assign s_axis_tready = !fifo_stat_i.full;
  assign push_o        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cur_col   = s_axis_tuser ? '0 : col_q;
    cur_row   = s_axis_tuser ? '0 : row_q;
    col_shift = cur_col >> 2;
    row_shift = cur_row >> 2;

    item_o.red   = s_axis_tdata[7:0];
    item_o.green = s_axis_tdata[15:8];
    item_o.blue  = s_axis_tdata[23:16];
    item_o.bcol  = col_shift[BC_W-1:0];
    item_o.brow  = 6'(row_shift);
    item_o.first = (cur_col[1:0] == 2'd0) && (cur_row[1:0] == 2'd0);
    item_o.last  = (cur_col[1:0] == 2'd3) && (cur_row[1:0] == 2'd3);

    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (cur_col == COL_LAST) begin
        col_d = '0;
        row_d = (cur_row == ROW_LAST) ? '0 : cur_row + ROW_W'(1);
      end else begin
        col_d = cur_col + COL_W'(1);
        row_d = cur_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: rtl/core/bavq_fifo.sv
// Short queue of tagged pixels between front and back end.
// Depends on bavq_pkg.
`timescale 1ns / 1ps

module bavq_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bavq_pkg::pix_item_t  item_i,
  input  logic                 pop_i,
  output bavq_pkg::pix_item_t  head_o,
  output bavq_pkg::fifo_stat_t stat_o
);
  import bavq_pkg::*;

  pix_item_t             slot_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FIFO_PTR_W:0]   cnt_q, cnt_d;

  always_comb begin
    wptr_d = push_i ? wptr_q + FIFO_PTR_W'(1) : wptr_q;
    rptr_d = pop_i  ? rptr_q + FIFO_PTR_W'(1) : rptr_q;
    cnt_d  = cnt_q + (FIFO_PTR_W + 1)'(push_i) - (FIFO_PTR_W + 1)'(pop_i);
  end

  assign head_o       = slot_q[rptr_q];
  assign stat_o.full  = (cnt_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/core/bavq_back.sv
// Back end: per-column-block accumulation in RAM with write forwarding,
// then mean, gray/cube classification, index and output register.
// Depends on bavq_pkg and bavq_ram.
`timescale 1ns / 1ps

module bavq_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bavq_pkg::pix_item_t head_i,
  input  logic                head_vld_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata    // color_index, block_col, block_row
);
  import bavq_pkg::*;

  logic en;

  // accumulate stage
  logic             b_vld_q;
  pix_item_t        b_item_q;
  logic [SUM_W-1:0] rd_data, base, sum;
  logic             wr_vld_q, hit, we;
  logic [BC_W-1:0]  wr_bc_q;
  logic [SUM_W-1:0] wr_sum_q;

  // classify stage
  logic             c_vld_q;
  logic [7:0]       c_r_q, c_g_q, c_b_q;
  logic [BC_W-1:0]  c_bc_q;
  logic [5:0]       c_brow_q;
  logic [7:0]       mx, mn, spread, gray;
  logic [9:0]       sum3;
  logic [19:0]      prod3;

  // index stage
  logic             d_vld_q;
  logic             d_near_q;
  logic [7:0]       d_gray_q;
  logic [2:0]       d_dr_q, d_dg_q, d_db_q;
  logic [BC_W-1:0]  d_bc_q;
  logic [5:0]       d_brow_q;
  logic [7:0]       v, idx;
  logic [15:0]      prod10;
  logic [8:0]       ramp;

  // output register
  logic             o_vld_q;
  logic [7:0]       o_idx_q;
  logic [5:0]       o_col_q, o_row_q;

  assign en    = !o_vld_q || m_axis_tready;
  assign pop_o = head_vld_i && en;
  assign we    = en && b_vld_q;

  bavq_ram #(
    .WIDTH (SUM_W),
    .DEPTH (NUM_BLOCK_COLS)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (b_item_q.bcol),
    .wdata_i (sum),
    .re_i    (en),
    .raddr_i (head_i.bcol),
    .rdata_o (rd_data)
  );

  always_comb begin
    hit  = wr_vld_q && (wr_bc_q == b_item_q.bcol);
    base = hit ? wr_sum_q : rd_data;
    if (b_item_q.first) begin
      sum = {CH_W'(b_item_q.red), CH_W'(b_item_q.green), CH_W'(b_item_q.blue)};
    end else begin
      sum[3*CH_W-1:2*CH_W] = base[3*CH_W-1:2*CH_W] + CH_W'(b_item_q.red);
      sum[2*CH_W-1:CH_W]   = base[2*CH_W-1:CH_W]   + CH_W'(b_item_q.green);
      sum[CH_W-1:0]        = base[CH_W-1:0]        + CH_W'(b_item_q.blue);
    end
  end

  always_comb begin
    mx = c_r_q;
    mn = c_r_q;
    if (c_g_q > mx) mx = c_g_q;
    if (c_b_q > mx) mx = c_b_q;
    if (c_g_q < mn) mn = c_g_q;
    if (c_b_q < mn) mn = c_b_q;
    spread = mx - mn;
    sum3   = 10'(c_r_q) + 10'(c_g_q) + 10'(c_b_q);
    prod3  = 20'(sum3) * RECIP3;
    gray   = prod3[18:11];
  end

  always_comb begin
    v      = d_gray_q - GRAY_LO;
    prod10 = 16'(v) * RECIP10;
    ramp   = IDX_RAMP + 9'(prod10[15:11]);
    if (d_near_q) begin
      if (d_gray_q < GRAY_LO) begin
        idx = IDX_BLACK;
      end else if (d_gray_q > GRAY_HI) begin
        idx = IDX_WHITE;
      end else begin
        idx = (ramp > IDX_MAX) ? IDX_MAX[7:0] : ramp[7:0];
      end
    end else begin
      idx = IDX_BLACK + CUBE_R_MUL * 8'(d_dr_q) + CUBE_G_MUL * 8'(d_dg_q) + 8'(d_db_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q  <= 1'b0;
      wr_vld_q <= 1'b0;
      c_vld_q  <= 1'b0;
      d_vld_q  <= 1'b0;
      o_vld_q  <= 1'b0;
    end else if (en) begin
      b_vld_q  <= pop_o;
      wr_vld_q <= wr_vld_q || b_vld_q;
      c_vld_q  <= b_vld_q && b_item_q.last;
      d_vld_q  <= c_vld_q;
      o_vld_q  <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_item_q <= head_i;
      if (b_vld_q) begin
        wr_bc_q  <= b_item_q.bcol;
        wr_sum_q <= sum;
      end
      c_r_q    <= sum[3*CH_W-1:3*CH_W-8];
      c_g_q    <= sum[2*CH_W-1:2*CH_W-8];
      c_b_q    <= sum[CH_W-1:CH_W-8];
      c_bc_q   <= b_item_q.bcol;
      c_brow_q <= b_item_q.brow;
      d_near_q <= spread < GRAY_SPREAD;
      d_gray_q <= gray;
      d_dr_q   <= cube_digit(c_r_q);
      d_dg_q   <= cube_digit(c_g_q);
      d_db_q   <= cube_digit(c_b_q);
      d_bc_q   <= c_bc_q;
      d_brow_q <= c_brow_q;
      o_idx_q  <= idx;
      o_col_q  <= 6'(d_bc_q);
      o_row_q  <= d_brow_q;
    end
  end

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = {4'd0, o_row_q, o_col_q, o_idx_q};

endmodule

FILE: rtl/core/block_average_xterm256_quantizer.sv
// Top level of the block average xterm-256 quantizer.
// Instantiates bavq_front, bavq_fifo and bavq_back; uses bavq_pkg.
//
// Input stream: one RGB pixel per transaction in raster order, s_axis_tuser
// marks the first pixel of a frame and restarts the position at 0,0. Frame
// size is IMAGE_WIDTH x IMAGE_HEIGHT from the package; the position also
// wraps after the last pixel of a frame.
// Output stream: one transaction per completed 4x4 block, triggered by the
// block's bottom-right pixel: xterm-256 index of the truncated channel
// means plus block column and row (low 6 bits each).
// Throughput: one pixel per clock while the output is not stalled, set by
// the single read and single write port of the column-block sum RAM
// (read-modify-write with forwarding). The block's last pixel passes the
// queue, then the accumulate, classify, index and output registers.
// Reset clears the position, queue and pipeline valids; no RAM clearing is
// needed since each block's first pixel loads its sum.
// When the receiver stalls, the result holds in the output register, the
// back end freezes and the 4-entry queue keeps taking pixels until full.
`timescale 1ns / 1ps

module block_average_xterm256_quantizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // red[7:0], green[15:8], blue[23:16]
  input  logic        s_axis_tuser,    // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata     // color_index[7:0], block_col[13:8], block_row[19:14]
);
  import bavq_pkg::*;

  pix_item_t  push_item, head_item;
  fifo_stat_t fifo_stat;
  logic       fifo_push, fifo_pop;

  bavq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .fifo_stat_i   (fifo_stat),
    .push_o        (fifo_push),
    .item_o        (push_item)
  );

  bavq_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fifo_push),
    .item_i (push_item),
    .pop_i  (fifo_pop),
    .head_o (head_item),
    .stat_o (fifo_stat)
  );

  bavq_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_item),
    .head_vld_i    (!fifo_stat.empty),
    .pop_o         (fifo_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] >= IDX_BLACK))
    else $error("color index below 16");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> !fifo_stat.empty)
    else $error("queue popped while empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_push && !fifo_pop) |=> !fifo_stat.empty)
    else $error("queued pixel lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.full |-> !s_axis_tready)
    else $error("pixel accepted into full queue");

endmodule

FILE: tb/bavq_tb_pkg.sv
// Scoreboard for the block average xterm-256 quantizer testbench.
// Predicts one color result per completed 4x4 block and checks the output stream.
// Depends on bavq_pkg for the image geometry.
`timescale 1ns / 1ps

package bavq_tb_pkg;

  import bavq_pkg::*;

  localparam int unsigned BLACK_IDX = 16;
  localparam int unsigned WHITE_IDX = 231;
  localparam int unsigned RAMP_BASE = 232;
  localparam int unsigned RAMP_TOP  = 255;

  typedef struct {
    logic [7:0] color;
    logic [5:0] bcol;
    logic [5:0] brow;
  } block_result_t;

  class block_color_scoreboard;

    int unsigned   column;
    int unsigned   row;
    logic [11:0]   red_sum   [NUM_BLOCK_COLS];
    logic [11:0]   green_sum [NUM_BLOCK_COLS];
    logic [11:0]   blue_sum  [NUM_BLOCK_COLS];
    block_result_t pending_blocks[$];
    int unsigned   predicted;
    int unsigned   errors;

    function new();
      column    = 0;
      row       = 0;
      predicted = 0;
      errors    = 0;
      for (int i = 0; i < NUM_BLOCK_COLS; i++) begin
        red_sum[i]   = '0;
        green_sum[i] = '0;
        blue_sum[i]  = '0;
      end
    endfunction

    function logic [7:0] xterm_index(int unsigned r, int unsigned g, int unsigned b);
      int unsigned hi;
      int unsigned lo;
      int unsigned gray;
      int unsigned idx;
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      if (hi - lo < 10) begin
        gray = (r + g + b) / 3;
        if (gray < 8) return 8'(BLACK_IDX);
        if (gray > 248) return 8'(WHITE_IDX);
        idx = RAMP_BASE + (gray - 8) * 24 / 240;
        // ramp top saturates
        return (idx > RAMP_TOP) ? 8'(RAMP_TOP) : 8'(idx);
      end
      return 8'(BLACK_IDX + 36 * (r * 5 / 255) + 6 * (g * 5 / 255) + (b * 5 / 255));
    endfunction

    // one accepted pixel transaction
    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic frame_start);
      int unsigned   bc;
      block_result_t res;
      if (frame_start) begin
        column = 0;
        row    = 0;
      end
      bc = column >> 2;
      if ((column % 4 == 0) && (row % 4 == 0)) begin
        red_sum[bc]   = 12'(r);
        green_sum[bc] = 12'(g);
        blue_sum[bc]  = 12'(b);
      end else begin
        red_sum[bc]   = red_sum[bc] + 12'(r);
        green_sum[bc] = green_sum[bc] + 12'(g);
        blue_sum[bc]  = blue_sum[bc] + 12'(b);
      end
      if ((column % 4 == 3) && (row % 4 == 3)) begin
        res.color = xterm_index(red_sum[bc] >> 4, green_sum[bc] >> 4, blue_sum[bc] >> 4);
        res.bcol  = 6'(bc);
        res.brow  = 6'(row >> 2);
        pending_blocks.push_back(res);
        predicted++;
      end
      column++;
      if (column >= IMAGE_WIDTH) begin
        column = 0;
        row++;
        if (row >= IMAGE_HEIGHT) row = 0;
      end
    endfunction

    // one accepted result transaction
    function void check_block(logic [23:0] data);
      block_result_t exp_res;
      if (pending_blocks.size() == 0) begin
        $error("unexpected result transaction: 0x%06h", data);
        errors++;
        return;
      end
      exp_res = pending_blocks.pop_front();
      if (data[7:0] !== exp_res.color) begin
        $error("color_index: expected %0d, actual %0d", exp_res.color, data[7:0]);
        errors++;
      end
      if (data[13:8] !== exp_res.bcol) begin
        $error("block_col: expected %0d, actual %0d", exp_res.bcol, data[13:8]);
        errors++;
      end
      if (data[19:14] !== exp_res.brow) begin
        $error("block_row: expected %0d, actual %0d", exp_res.brow, data[19:14]);
        errors++;
      end
    endfunction

  endclass

endpackage

FILE: tb/tb_top.sv
// Top-level testbench for block_average_xterm256_quantizer.
// Streams probe-color and random pixels over one band and checks every block color.
// Depends on bavq_pkg, bavq_tb_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

  import bavq_pkg::*;
  import bavq_tb_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // red[7:0], green[15:8], blue[23:16]
  logic        s_axis_tuser;   // frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // color_index[7:0], block_col[13:8], block_row[19:14]

  block_color_scoreboard sb;

  bit          idle_on;
  bit          hold_req;
  logic [7:0]  base_r [NUM_BLOCK_COLS];
  logic [7:0]  base_g [NUM_BLOCK_COLS];
  logic [7:0]  base_b [NUM_BLOCK_COLS];
  int          jit    [NUM_BLOCK_COLS];

  block_average_xterm256_quantizer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [23:0] rgb(int r, int g, int b);
    return {8'(b), 8'(g), 8'(r)};
  endfunction

  // solid color per block column: gray ends, ramp top, spread edge, cube corners
  function automatic logic [23:0] probe_color(int bc);
    case (bc % 16)
      0:       return rgb(0, 0, 0);
      1:       return rgb(7, 7, 7);
      2:       return rgb(8, 8, 8);
      3:       return rgb(18, 18, 18);
      4:       return rgb(128, 128, 128);
      5:       return rgb(247, 247, 247);
      6:       return rgb(248, 248, 248);
      7:       return rgb(249, 249, 249);
      8:       return rgb(255, 255, 255);
      9:       return rgb(100, 109, 100);
      10:      return rgb(100, 110, 100);
      11:      return rgb(255, 0, 0);
      12:      return rgb(0, 255, 0);
      13:      return rgb(0, 0, 255);
      14:      return rgb(0, 0, 10);
      default: return rgb(254, 51, 50);
    endcase
  endfunction

  function automatic logic [7:0] jittered(logic [7:0] base, int j);
    int x;
    x = int'(base) + int'($urandom_range(2 * j)) - j;
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return 8'(x);
  endfunction

  task automatic restyle();
    int mode;
    int v;
    for (int i = 0; i < NUM_BLOCK_COLS; i++) begin
      mode = $urandom_range(3);
      case (mode)
        0: begin
          base_r[i] = 8'd128;
          base_g[i] = 8'd128;
          base_b[i] = 8'd128;
          jit[i]    = 128;
        end
        1: begin
          v         = $urandom_range(255);
          base_r[i] = 8'(v);
          base_g[i] = 8'(v);
          base_b[i] = 8'(v);
          jit[i]    = $urandom_range(12);
        end
        2: begin
          base_r[i] = 8'($urandom_range(255));
          base_g[i] = 8'($urandom_range(255));
          base_b[i] = 8'($urandom_range(255));
          jit[i]    = $urandom_range(40);
        end
        default: begin
          base_r[i] = ($urandom_range(1) != 0) ? 8'd248 : 8'd8;
          base_g[i] = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
          base_b[i] = ($urandom_range(1) != 0) ? 8'd248 : 8'd8;
          jit[i]    = $urandom_range(3);
        end
      endcase
    end
  endtask

  // entered and left at a falling edge
  task automatic send_pixel(logic [23:0] px, logic frame_start);
    while (idle_on && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= frame_start;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel(px[7:0], px[15:8], px[23:16], frame_start);
    @(negedge clk_i);
  endtask

  // left half of the columns carries probe colors, right half random styles
  task automatic send_pixels(int count, int first_p, bit fs_first, bit hold);
    int          bc;
    logic [23:0] px;
    for (int p = first_p; p < first_p + count; p++) begin
      bc = (p % IMAGE_WIDTH) / 4;
      if (bc < NUM_BLOCK_COLS / 2) begin
        px = probe_color(bc);
      end else begin
        px = {jittered(base_b[bc], jit[bc]), jittered(base_g[bc], jit[bc]),
              jittered(base_r[bc], jit[bc])};
      end
      if (hold && p == 3 * IMAGE_WIDTH) hold_req = 1'b1;
      send_pixel(px, fs_first && p == first_p);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending_blocks.size() != 0) @(negedge clk_i);
  endtask

  // receiver
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (300) @(negedge clk_i);
      end
      m_axis_tready <= !(idle_on && $urandom_range(99) < 33);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_block(m_axis_tdata);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    sb            = new();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    restyle();

    // part of row 0 without idling, cut short by the next frame start
    idle_on = 1'b0;
    send_pixels($urandom_range(128, IMAGE_WIDTH - 1), 0, 1'b1, 1'b0);
    idle_on = 1'b1;

    // one full band, receiver held off in the bottom row, sender pauses mid-row
    send_pixels(3 * IMAGE_WIDTH + IMAGE_WIDTH / 2, 0, 1'b1, 1'b1);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    send_pixels(IMAGE_WIDTH / 2, 3 * IMAGE_WIDTH + IMAGE_WIDTH / 2, 1'b0, 1'b0);
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (sb.pending_blocks.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_blocks.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/bavq_pkg.sv
rtl/core/bavq_ram.sv
rtl/core/bavq_front.sv
rtl/core/bavq_fifo.sv
rtl/core/bavq_back.sv
rtl/core/block_average_xterm256_quantizer.sv
tb/bavq_tb_pkg.sv
tb/tb_top.sv
